// File: hw/rtl/mxpsl_pkg.sv
// ----------------------------------------------------------------------------
// mxpsl_pkg
// shared constants and types of the preference sorted list
// ----------------------------------------------------------------------------
`default_nettype none

package mxpsl_pkg;

    localparam int LIST_DEPTH_DEFAULT = 10;

    localparam int MODE_W  = 2;
    localparam int HOST_W  = 16;
    localparam int PREF_W  = 16;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 4;

    // stored word: host, preference, local mark
    localparam int ENTRY_W = HOST_W + PREF_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_FINAL  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

endpackage

`default_nettype wire

// File: hw/rtl/mxpsl_ram.sv
// ----------------------------------------------------------------------------
// mxpsl_ram
// simple dual port ram, one write and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mxpsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/mx_preference_sorted_list_unit.sv
// ----------------------------------------------------------------------------
// mx_preference_sorted_list_unit
// bounded list of mail exchanger entries kept sorted by ascending preference
//
// input channel (i_valid / o_stall) carries one beat per command: insert,
// finalize (truncate at the first local entry), read of a slot or no-op. every
// beat gives exactly one result beat on the output channel (o_valid /
// i_stall) with the read entry, the live count and the stored flag.
// entries live in one ram; live entries always fill slots 0 to count-1, so
// a slot at or beyond count reads as empty and reset only clears the count.
// one comparator walks the slots, each slot a ram read and then a compare.
// insert: scan slots until the insert point is found or the scan runs past
// the last entry, move each entry below it down one slot (read, write), then
// write the new entry and post the result.
// finalize: scan slots up to the first local entry, then post the result.
// read: the slot is read unless empty. the next command is taken in the
// cycle after the result is posted. o_stall is high from accept until the
// result is posted; the result register holds while i_stall is high, and a
// new command is taken meanwhile, its result waiting until the register is
// free. reset (synchronous, active low) empties the list and drops the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mx_preference_sorted_list_unit #(
    parameter int LIST_DEPTH = mxpsl_pkg::LIST_DEPTH_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [mxpsl_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [mxpsl_pkg::HOST_W-1:0]   i_host_id,
    input  wire logic [mxpsl_pkg::PREF_W-1:0]   i_pref,
    input  wire logic                           i_is_local,
    input  wire logic [mxpsl_pkg::INDEX_W-1:0]  i_index,

    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_entry_valid,
    output logic      [mxpsl_pkg::HOST_W-1:0]   o_entry_host,
    output logic      [mxpsl_pkg::PREF_W-1:0]   o_entry_pref,
    output logic                                o_entry_local,
    output logic      [mxpsl_pkg::COUNT_W-1:0]  o_count,
    output logic                                o_stored
);

    import mxpsl_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int XW = (IW > COUNT_W) ? IW : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_READ_RD,
        S_READ_DAT,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [HOST_W-1:0]   r_host, n_host;
    logic [PREF_W-1:0]   r_pref, n_pref;
    logic                r_loc, n_loc;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic [CW-1:0]       r_k, n_k;
    logic [AW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_newcount, n_newcount;

    logic                r_res_valid, n_res_valid;
    logic [HOST_W-1:0]   r_res_host, n_res_host;
    logic [PREF_W-1:0]   r_res_pref, n_res_pref;
    logic                r_res_local, n_res_local;
    logic                r_res_stored, n_res_stored;

    logic                r_out_valid, n_out_valid;
    logic                r_out_entry_valid, n_out_entry_valid;
    logic [HOST_W-1:0]   r_out_host, n_out_host;
    logic [PREF_W-1:0]   r_out_pref, n_out_pref;
    logic                r_out_local, n_out_local;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic                r_out_stored, n_out_stored;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [HOST_W-1:0]   slot_host;
    logic [PREF_W-1:0]   slot_pref;
    logic                slot_local;
    logic [CW-1:0]       grow_count;
    logic [IW-1:0]       index_ext;
    logic [IW-1:0]       count_ext;
    logic [XW-1:0]       count_out;
    logic                out_free;

    mxpsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_host  = ram_rdata[ENTRY_W-1:PREF_W+1];
    assign slot_pref  = ram_rdata[PREF_W:1];
    assign slot_local = ram_rdata[0];
    assign grow_count = (r_count == CW'(LIST_DEPTH)) ? r_count : r_count + 1'b1;
    assign index_ext  = IW'(i_index);
    assign count_ext  = IW'(r_count);
    assign count_out  = XW'(r_count);
    assign out_free   = !r_out_valid || !i_stall;

    always_comb begin
        n_state           = r_state;
        n_mode            = r_mode;
        n_host            = r_host;
        n_pref            = r_pref;
        n_loc             = r_loc;
        n_index           = r_index;
        n_k               = r_k;
        n_j               = r_j;
        n_count           = r_count;
        n_newcount        = r_newcount;
        n_res_valid       = r_res_valid;
        n_res_host        = r_res_host;
        n_res_pref        = r_res_pref;
        n_res_local       = r_res_local;
        n_res_stored      = r_res_stored;
        n_out_valid       = r_out_valid && i_stall;
        n_out_entry_valid = r_out_entry_valid;
        n_out_host        = r_out_host;
        n_out_pref        = r_out_pref;
        n_out_local       = r_out_local;
        n_out_count       = r_out_count;
        n_out_stored      = r_out_stored;
        ram_we            = 1'b0;
        ram_waddr         = r_j;
        ram_wdata         = ram_rdata;
        ram_raddr         = r_k[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode       = t_mode'(i_mode);
                    n_host       = i_host_id;
                    n_pref       = i_pref;
                    n_loc        = i_is_local;
                    n_index      = i_index;
                    n_k          = '0;
                    n_res_valid  = 1'b0;
                    n_res_host   = '0;
                    n_res_pref   = '0;
                    n_res_local  = 1'b0;
                    n_res_stored = 1'b0;
                    case (t_mode'(i_mode))
                        MODE_INSERT, MODE_FINAL: n_state = S_SCAN_RD;
                        MODE_READ: begin
                            n_state = (index_ext < count_ext) ? S_READ_RD : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_k >= r_count) begin
                    if (r_mode == MODE_INSERT && r_k != CW'(LIST_DEPTH)) begin
                        n_newcount = grow_count;
                        n_j        = AW'(grow_count - 1'b1);
                        n_state    = S_SHIFT_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    ram_raddr = r_k[AW-1:0];
                    n_state   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (r_mode == MODE_INSERT) begin
                    if (r_pref < slot_pref) begin
                        n_newcount = grow_count;
                        n_j        = AW'(grow_count - 1'b1);
                        n_state    = S_SHIFT_RD;
                    end else if (r_pref == slot_pref) begin
                        if (slot_local) begin
                            n_state = S_DONE;
                        end else if (r_loc) begin
                            n_newcount = r_k + 1'b1;
                            n_state    = S_PUT;
                        end else begin
                            n_newcount = grow_count;
                            n_j        = AW'(grow_count - 1'b1);
                            n_state    = S_SHIFT_RD;
                        end
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    if (slot_local) begin
                        n_count = r_k;
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SHIFT_RD: begin
                if (r_j == r_k[AW-1:0]) begin
                    n_state = S_PUT;
                end else begin
                    ram_raddr = r_j - 1'b1;
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = ram_rdata;
                n_j       = r_j - 1'b1;
                n_state   = S_SHIFT_RD;
            end
            S_PUT: begin
                ram_we       = 1'b1;
                ram_waddr    = r_k[AW-1:0];
                ram_wdata    = {r_host, r_pref, r_loc};
                n_count      = r_newcount;
                n_res_stored = 1'b1;
                n_state      = S_DONE;
            end
            S_READ_RD: begin
                ram_raddr = AW'(r_index);
                n_state   = S_READ_DAT;
            end
            S_READ_DAT: begin
                n_res_valid = 1'b1;
                n_res_host  = slot_host;
                n_res_pref  = slot_pref;
                n_res_local = slot_local;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out_entry_valid = r_res_valid;
                    n_out_host        = r_res_host;
                    n_out_pref        = r_res_pref;
                    n_out_local       = r_res_local;
                    n_out_count       = count_out[COUNT_W-1:0];
                    n_out_stored      = r_res_stored;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_mode            <= n_mode;
        r_host            <= n_host;
        r_pref            <= n_pref;
        r_loc             <= n_loc;
        r_index           <= n_index;
        r_k               <= n_k;
        r_j               <= n_j;
        r_newcount        <= n_newcount;
        r_res_valid       <= n_res_valid;
        r_res_host        <= n_res_host;
        r_res_pref        <= n_res_pref;
        r_res_local       <= n_res_local;
        r_res_stored      <= n_res_stored;
        r_out_entry_valid <= n_out_entry_valid;
        r_out_host        <= n_out_host;
        r_out_pref        <= n_out_pref;
        r_out_local       <= n_out_local;
        r_out_count       <= n_out_count;
        r_out_stored      <= n_out_stored;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_entry_valid = r_out_entry_valid;
    assign o_entry_host  = r_out_host;
    assign o_entry_pref  = r_out_pref;
    assign o_entry_local = r_out_local;
    assign o_count       = r_out_count;
    assign o_stored      = r_out_stored;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("live count above list depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("live count grew by more than one");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CW'(ram_waddr) < CW'(LIST_DEPTH)))
        else $error("ram write beyond list depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("not busy after accepting a beat");

endmodule

`default_nettype wire
